### hw/rtl/multicast_hash_filter_update_macros.svh
// assertion macros for the multicast hash filter update block
// no dependencies; included by the modules that carry assertions
`ifndef MULTICAST_HASH_FILTER_UPDATE_MACROS_SVH
`define MULTICAST_HASH_FILTER_UPDATE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MHF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mhf same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MHF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mhf next-cycle check failed");

`endif

### hw/rtl/mhf_pkg.sv
// shared types, constants and crc helpers for the multicast hash filter update
// no dependencies; imported by every module of the block
package mhf_pkg;

	localparam int MacBytes = 6;
	localparam int MacBits = 8 * MacBytes;
	localparam int CrcBits = 32;
	localparam int IndexBits = 6;
	localparam int TableBits = 64;
	localparam int WordBits = 32;

	localparam logic [CrcBits-1:0] CrcPoly = 32'h04C11DB7;
	localparam logic [CrcBits-1:0] CrcInit = 32'hFFFFFFFF;
	localparam logic [7:0] GroupOuiHigh = 8'h01;
	localparam logic [7:0] GroupOuiMid = 8'h00;
	localparam logic [7:0] GroupOuiLow = 8'h5E;
	localparam logic [6:0] GroupMask = 7'h7F;

	// request action codes
	localparam logic ActGroup = 1'b0;
	localparam logic ActMac = 1'b1;

	typedef struct packed {
		logic action;
		logic [31:0] group_address;
		logic [47:0] mac_address;
	} mhf_req_t;

	typedef struct packed {
		logic [IndexBits-1:0] hash_index;
		logic [TableBits-1:0] hash_table;
	} mhf_rsp_t;

	// table update request between top and table
	typedef struct packed {
		logic en;
		logic [IndexBits-1:0] index;
	} mhf_upd_t;

	typedef logic [CrcBits-1:0][MacBits-1:0] crc_mask_t;

	// bit-serial crc, used only at elaboration to build the xor network
	function automatic logic [CrcBits-1:0] crc_serial(input logic [MacBits-1:0] mac,
		input logic [CrcBits-1:0] init);
		logic [CrcBits-1:0] crc;
		logic fb;
		crc = init;
		for (int b = 0; b < MacBytes; b++) begin
			for (int k = 0; k < 8; k++) begin
				fb = crc[CrcBits-1] ^ mac[8 * (MacBytes - 1 - b) + k];
				crc = {crc[CrcBits-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
			end
		end
		return crc;
	endfunction

	// row i: which mac bits feed crc bit i
	function automatic crc_mask_t crc_masks();
		crc_mask_t m;
		logic [CrcBits-1:0] col;
		m = '0;
		for (int j = 0; j < MacBits; j++) begin
			col = crc_serial({{(MacBits-1){1'b0}}, 1'b1} << j, '0);
			for (int i = 0; i < CrcBits; i++) begin
				m[i][j] = col[i];
			end
		end
		return m;
	endfunction

	localparam crc_mask_t CrcMasks = crc_masks();
	localparam logic [CrcBits-1:0] CrcZeroResp = crc_serial('0, CrcInit);

	// top bits of the inverted crc as a parallel xor network
	function automatic logic [IndexBits-1:0] mac_hash_index(input logic [MacBits-1:0] mac);
		logic [IndexBits-1:0] idx;
		for (int i = 0; i < IndexBits; i++) begin
			idx[i] = ~(CrcZeroResp[CrcBits-IndexBits+i]
				^ (^(mac & CrcMasks[CrcBits-IndexBits+i])));
		end
		return idx;
	endfunction

endpackage

### hw/rtl/multicast_hash_filter_update.sv
// top level of the multicast hash filter update: handshake, pipeline registers
// depends on mhf_pkg, mhf_hash, mhf_table and the block assertion macros
//
//   channel  dir  handshake              payload
//   req      in   req_valid, req_stall   mhf_req_t (action, group_address, mac_address)
//   rsp      out  rsp_valid, rsp_stall   mhf_rsp_t (hash_index, hash_table)
//
// one item per cycle sustained while rsp_stall is low; an accepted item passes
// through the input register into the result register, where rsp_valid rises
// the crc is a fixed xor network between the input register and the result register
// reset clears both valid bits and the table; payload registers are not reset
// a stalled rsp holds its result; the input register still takes one more item,
// then req_stall rises until the result is taken
`include "multicast_hash_filter_update_macros.svh"

module multicast_hash_filter_update (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  mhf_pkg::mhf_req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output mhf_pkg::mhf_rsp_t rsp
);
	import mhf_pkg::*;

	// input register
	logic valid_s1;
	mhf_req_t req_s1;

	// result register
	logic valid_s2;
	mhf_rsp_t rsp_s2;

	logic adv_s2;
	logic [IndexBits-1:0] idx_s1;
	logic [TableBits-1:0] table_upd;
	mhf_upd_t upd;

	// result register is free or draining this cycle
	assign adv_s2 = !valid_s2 || !rsp_stall;
	// input register can only hold while its item cannot move on
	assign req_stall = valid_s1 && !adv_s2;

	mhf_hash u_hash (
		.req        (req_s1),
		.hash_index (idx_s1)
	);

	// table commits exactly when the item moves into the result register
	assign upd.en = valid_s1 && adv_s2;
	assign upd.index = idx_s1;

	mhf_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.upd       (upd),
		.table_upd (table_upd)
	);

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!req_stall) begin
				valid_s1 <= req_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (upd.en) begin
			rsp_s2.hash_index <= idx_s1;
			rsp_s2.hash_table <= table_upd;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp = rsp_s2;

	// a full pipe behind a stalled result must push back on the input
	`MHF_ASSERT_NOW(a_full_stall, clk, arst_n, valid_s1 && valid_s2 && rsp_stall, req_stall)
	// an item moving forward shows up as a result next cycle
	`MHF_ASSERT_NEXT(a_adv_valid, clk, arst_n, upd.en, valid_s2)
	// every result carries its own bit set in the table
	`MHF_ASSERT_NOW(a_rsp_bit, clk, arst_n, valid_s2, rsp_s2.hash_table[rsp_s2.hash_index])

endmodule

### hw/rtl/mhf_hash.sv
// mac formation and crc-32 hash index for one request
// depends on mhf_pkg
module mhf_hash (
	input  mhf_pkg::mhf_req_t req,
	output logic [mhf_pkg::IndexBits-1:0] hash_index
);
	import mhf_pkg::*;

	logic [MacBits-1:0] mac;

	always_comb begin
		if (req.action == ActGroup) begin
			// ipv4 group maps onto 01:00:5e plus low 23 group bits
			mac = {GroupOuiHigh, GroupOuiMid, GroupOuiLow,
				1'b0, req.group_address[22:16] & GroupMask,
				req.group_address[15:0]};
		end else begin
			mac = req.mac_address;
		end
	end

	assign hash_index = mac_hash_index(mac);

endmodule

### hw/rtl/mhf_table.sv
// 64-bit hash table held as two 32-bit words, set-only update
// depends on mhf_pkg and the block assertion macros
`include "multicast_hash_filter_update_macros.svh"

module mhf_table (
	input  logic clk,
	input  logic arst_n,
	input  mhf_pkg::mhf_upd_t upd,
	output logic [mhf_pkg::TableBits-1:0] table_upd
);
	import mhf_pkg::*;

	logic [WordBits-1:0] table_high_q;
	logic [WordBits-1:0] table_low_q;
	logic [TableBits-1:0] cur_table;
	logic [TableBits-1:0] set_bit;

	assign cur_table = {table_high_q, table_low_q};
	assign set_bit = {{(TableBits-1){1'b0}}, 1'b1} << upd.index;
	assign table_upd = cur_table | set_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_high_q <= '0;
			table_low_q <= '0;
		end else if (upd.en) begin
			table_high_q <= table_upd[TableBits-1:WordBits];
			table_low_q <= table_upd[WordBits-1:0];
		end
	end

	// bits are only ever set
	`MHF_ASSERT_NEXT(a_tbl_no_clear, clk, arst_n, 1'b1,
		(cur_table & $past(cur_table)) == $past(cur_table))
	// an update sets its bit
	`MHF_ASSERT_NEXT(a_tbl_bit_set, clk, arst_n, upd.en, cur_table[$past(upd.index)])
	// the table only changes on an update
	`MHF_ASSERT_NEXT(a_tbl_hold, clk, arst_n, !upd.en, $stable(cur_table))

endmodule

### tb/mhf_hash_check.sv
// checker for the multicast hash filter update: watches both channels,
// predicts index and table for each accepted request and compares results
// depends on mhf_pkg for the payload types and crc constants
module mhf_hash_check (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  mhf_pkg::mhf_req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  mhf_pkg::mhf_rsp_t rsp,
	output int mismatches,
	output int results_due
);
	import mhf_pkg::*;

	logic [TableBits-1:0] filter_bits = '0;
	mhf_rsp_t due_q[$];

	// crc-32 over the six destination bytes, each byte lsb first, inverted
	function automatic logic [IndexBits-1:0] filter_hash_index(input mhf_req_t item);
		logic [MacBits-1:0] dest;
		logic [CrcBits-1:0] crc;
		logic [7:0] octet;
		logic fb;
		if (item.action == ActGroup)
			dest = {GroupOuiHigh, GroupOuiMid, GroupOuiLow, 1'b0, item.group_address[22:0]};
		else
			dest = item.mac_address;
		crc = CrcInit;
		for (int b = 0; b < MacBytes; b++) begin
			octet = dest[8 * (MacBytes - 1 - b) +: 8];
			for (int k = 0; k < 8; k++) begin
				fb = crc[CrcBits-1] ^ octet[k];
				crc = {crc[CrcBits-2:0], 1'b0} ^ (fb ? CrcPoly : '0);
			end
		end
		crc = ~crc;
		return crc[CrcBits-1 -: IndexBits];
	endfunction

	always @(posedge clk) begin
		mhf_rsp_t want;
		logic [IndexBits-1:0] idx;
		if (arst_n) begin
			// a result taken now always belongs to an older request
			if (rsp_valid && !rsp_stall) begin
				if (due_q.size() == 0) begin
					$display("%0t: unexpected result: index %0d table %h",
						$time, rsp.hash_index, rsp.hash_table);
					mismatches++;
				end else begin
					want = due_q.pop_front();
					if (rsp.hash_index !== want.hash_index) begin
						$display("%0t: hash_index expected %0d actual %0d",
							$time, want.hash_index, rsp.hash_index);
						mismatches++;
					end
					if (rsp.hash_table !== want.hash_table) begin
						$display("%0t: hash_table expected %h actual %h",
							$time, want.hash_table, rsp.hash_table);
						mismatches++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				idx = filter_hash_index(req);
				filter_bits[idx] = 1'b1;
				want.hash_index = idx;
				want.hash_table = filter_bits;
				due_q.push_back(want);
			end
			results_due = due_q.size();
		end
	end

endmodule

### tb/tb_top.sv
// top of the multicast hash filter update testbench: clock, reset, request
// stimulus, receiver stall pattern and the verdict
// depends on mhf_pkg, the block and the mhf_hash_check checker
module tb_top;
	import mhf_pkg::*;

	localparam int ResetCycles = 6;
	localparam int RandomItems = 1080;
	localparam int HoldOffAt = 300;     // items sent before the long receiver hold-off
	localparam int HoldOffCycles = 400;
	localparam int DrainCycles = 10;    // margin for a stray result after the drain
	localparam int CycleLimit = 300000;

	// receiver behavior between mode changes
	typedef enum int {StallNone, StallLight, StallHalf, StallHeavy} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	mhf_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	mhf_rsp_t rsp;

	int mismatches;
	int results_due;
	int items_sent = 0;
	int cycle_count = 0;

	// sender burst state
	int burst_left = 0;
	int gap_left = 0;

	multicast_hash_filter_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	mhf_hash_check checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.mismatches(mismatches),
		.results_due(results_due)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// run limit, counted on rising edges
	initial begin
		while (cycle_count < CycleLimit) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL multicast_hash_filter_update");
		$finish;
	end

	function automatic mhf_req_t group_req(input logic [31:0] group, input logic [47:0] filler);
		mhf_req_t item;
		item.action = ActGroup;
		item.group_address = group;
		item.mac_address = filler;
		return item;
	endfunction

	function automatic mhf_req_t mac_req(input logic [47:0] mac, input logic [31:0] filler);
		mhf_req_t item;
		item.action = ActMac;
		item.group_address = filler;
		item.mac_address = mac;
		return item;
	endfunction

	// random request; about half look like real multicast traffic, the rest is arbitrary
	function automatic mhf_req_t random_req();
		mhf_req_t item;
		logic [63:0] wide;
		int shape;
		shape = $urandom_range(0, 9);
		wide = {$urandom, $urandom};
		item.action = ($urandom_range(0, 1) == 0) ? ActGroup : ActMac;
		item.group_address = $urandom;
		item.mac_address = wide[47:0];
		// class d group range 224.0.0.0/4
		if (shape < 6)
			item.group_address[31:28] = 4'hE;
		// ipv4 multicast mac prefix with bit 23 clear
		if (shape < 4)
			item.mac_address[47:23] = {GroupOuiHigh, GroupOuiMid, GroupOuiLow, 1'b0};
		return item;
	endfunction

	// offer one item: maybe a gap first, then hold valid and payload until taken
	task automatic send_item(input mhf_req_t item);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			// some bursts follow straight on, others after a pause
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
		end
		while (gap_left > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			gap_left--;
		end
		@(negedge clk);
		req_valid <= 1'b1;
		req <= item;
		// accepted at the first rising edge with no stall
		do
			@(posedge clk);
		while (req_stall);
		items_sent++;
		burst_left--;
	endtask

	// receiver: random stall modes, plus one long hold-off to back the block up
	initial begin
		stall_mode_t mode;
		int mode_left;
		int hold_left;
		bit held;
		mode = StallNone;
		mode_left = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && items_sent >= HoldOffAt) begin
				held = 1'b1;
				hold_left = HoldOffCycles;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(10, 150);
				end
				mode_left--;
				case (mode)
					StallNone: rsp_stall <= 1'b0;
					StallLight: rsp_stall <= ($urandom_range(0, 3) == 0);
					StallHalf: rsp_stall <= ($urandom_range(0, 1) == 0);
					default: rsp_stall <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// stimulus and verdict
	initial begin
		repeat (ResetCycles) @(negedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, both actions
		send_item(group_req(32'h0000_0000, 48'h0));
		send_item(group_req(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
		send_item(mac_req(48'h0, 32'h0));
		send_item(mac_req(48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF));
		// all-hosts group and its mac spelled out: same bit, already set
		send_item(group_req(32'hE000_0001, 48'hA5A5_A5A5_A5A5));
		send_item(mac_req(48'h0100_5E00_0001, 32'h1234_5678));
		send_item(group_req(32'hE000_0001, 48'h5A5A_5A5A_5A5A));
		// top group bits 31:23 never reach the mac
		send_item(group_req(32'hEF80_0001, 48'h0));
		send_item(group_req(32'h0000_0001, 48'h0));
		send_item(group_req(32'hFF80_0001, 48'hFFFF_FFFF_FFFF));
		send_item(group_req(32'hEFFF_FFFF, 48'h0));
		send_item(group_req(32'h007F_FFFF, 48'h0));
		// the unused field swings while the used one stays put
		send_item(mac_req(48'h0100_5E7F_FFFF, 32'h0));
		send_item(mac_req(48'h0100_5E7F_FFFF, 32'hFFFF_FFFF));
		send_item(mac_req(48'h3333_0000_0001, 32'hE000_00FB));
		send_item(mac_req(48'h8000_0000_0000, 32'h0));
		send_item(mac_req(48'h0000_0000_0001, 32'h0));
		send_item(group_req(32'hE000_00FB, 48'h8000_0000_0001));
		send_item(group_req(32'hE455_AA55, 48'h0));
		send_item(mac_req(48'hAAAA_AAAA_AAAA, 32'h5555_5555));

		repeat (RandomItems) send_item(random_req());

		@(negedge clk);
		req_valid <= 1'b0;

		// drain, then give any stray result time to show up
		while (results_due != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		if (mismatches == 0)
			$display("PASS multicast_hash_filter_update");
		else
			$display("FAIL multicast_hash_filter_update");
		$finish;
	end

endmodule
